// File: design/cps_pkg.sv
// cps_pkg: shared types and constants for the calibration series evaluator.
// Holds the item structs, configuration struct, register codes and FSM states.
// No dependencies.
package cps_pkg;

	localparam int          ONE_Q16  = 65536;
	localparam logic [31:0] Q16_ONE  = 32'sd65536;

	localparam logic [1:0] CFG_SERIES_TYPE = 2'd0;
	localparam logic [1:0] CFG_TERM_COUNT  = 2'd1;
	localparam logic [1:0] CFG_RANGE_MIN   = 2'd2;
	localparam logic [1:0] CFG_RANGE_MAX   = 2'd3;

	localparam logic [1:0] TYPE_CHEB       = 2'd1;
	localparam logic [1:0] TYPE_CHEB_SHIFT = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef struct packed {
		logic               func;
		logic [4:0]         coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [31:0] sample;
	} cps_in_t;

	typedef struct packed {
		logic signed [31:0] series_value;
		logic               saturated;
	} cps_out_t;

	typedef struct packed {
		logic [1:0]         series_type;
		logic [4:0]         term_count;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
	} cps_cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_P_ACC0,
		S_P_MUL,
		S_P_ADD,
		S_C_NORM,
		S_C_DIV,
		S_C_A0,
		S_C_MU,
		S_C_T,
		S_C_MC,
		S_C_SA,
		S_FIN
	} cps_state_t;

endpackage

// File: design/cps_coeff_mem.sv
// cps_coeff_mem: coefficient store, one write port and one registered read port.
// Depends on nothing.
module cps_coeff_mem #(
	parameter int WORDS = 32,
	parameter int AW    = 5
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic signed [31:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic signed [31:0] rd_data
);

	logic signed [31:0] mem_q [WORDS];
	logic signed [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/cps_norm_div.sv
// cps_norm_div: restoring divider for range normalisation, one quotient bit a cycle.
// Computes floor((num << 16) / den) for num < den. No dependencies.
module cps_norm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [15:0] quo
);

	logic [31:0] r_q;
	logic [31:0] den_q;
	logic [15:0] q_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] r2;
	logic        ge;

	assign r2 = {r_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num;
			den_q <= den;
		end else if (busy_q) begin
			r_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			q_q <= {q_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// File: design/cps_seq.sv
// cps_seq: evaluation sequencer with one shared multiplier and the normaliser.
// Depends on cps_pkg and cps_norm_div; reads coefficients through an external port.
module cps_seq #(
	parameter int COEFF_WORDS = 32,
	parameter int AW          = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::cps_cfg_t  cfg,
	input  logic               start,
	input  logic signed [31:0] x,
	output logic               idle,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic signed [31:0] rd_data,
	output logic               res_valid,
	input  logic               res_ready,
	output cps_pkg::cps_out_t  res
);
	import cps_pkg::*;

	cps_state_t st_q, st_d;

	logic signed [31:0] x_q, u_q, t0_q, t1_q, acc_q;
	logic signed [53:0] sum_q;
	logic signed [63:0] prod_q;
	logic [4:0]         n_q;
	logic               flag_q;
	logic               oob_q;

	logic [4:0]         rd_idx;
	logic               div_start, div_done;
	logic [15:0]        div_quo;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, rnd16, rnd15, t2_raw, pa_raw, u2_raw, sum_w;
	logic signed [31:0] coef, xc, u_div;
	logic               have_range, cheb;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

	assign have_range = cfg.range_min < cfg.range_max;
	assign cheb = (cfg.series_type == TYPE_CHEB) || (cfg.series_type == TYPE_CHEB_SHIFT);
	assign coef = oob_q ? 32'sd0 : rd_data;

	always_comb begin
		xc = x;
		if (have_range) begin
			if (x < cfg.range_min) xc = cfg.range_min;
			else if (x > cfg.range_max) xc = cfg.range_max;
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign rnd16  = (prod_q + 64'sd32768) >>> 16;
	assign rnd15  = (prod_q + 64'sd16384) >>> 15;
	assign t2_raw = rnd15 - 64'(t0_q);
	assign pa_raw = rnd16 + 64'(coef);
	assign u2_raw = (64'(x_q) <<< 1) - 64'(Q16_ONE);
	assign sum_w  = 64'(sum_q);
	assign u_div  = $signed({15'b0, div_quo, 1'b0}) - Q16_ONE;

	cps_norm_div u_div_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (32'(x_q - cfg.range_min)),
		.den    (32'(cfg.range_max - cfg.range_min)),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		rd_en     = 1'b0;
		rd_idx    = 5'd0;
		div_start = 1'b0;
		mul_a     = x_q;
		mul_b     = acc_q;
		res_valid = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					if (cfg.term_count == 5'd0) begin
						st_d = S_FIN;
					end else if (cheb) begin
						st_d = S_C_NORM;
					end else begin
						rd_en  = 1'b1;
						rd_idx = cfg.term_count - 5'd1;
						st_d   = S_P_ACC0;
					end
				end
			end
			S_P_ACC0: begin
				if (cfg.term_count == 5'd1) begin
					st_d = S_FIN;
				end else begin
					rd_en  = 1'b1;
					rd_idx = cfg.term_count - 5'd2;
					st_d   = S_P_MUL;
				end
			end
			S_P_MUL: begin
				st_d = S_P_ADD;
			end
			S_P_ADD: begin
				if (n_q == 5'd1) begin
					st_d = S_FIN;
				end else begin
					rd_en  = 1'b1;
					rd_idx = n_q - 5'd2;
					st_d   = S_P_MUL;
				end
			end
			S_C_NORM: begin
				if (have_range && x_q > cfg.range_min && x_q < cfg.range_max) begin
					div_start = 1'b1;
					st_d      = S_C_DIV;
				end else begin
					rd_en = 1'b1;
					st_d  = S_C_A0;
				end
			end
			S_C_DIV: begin
				if (div_done) begin
					rd_en = 1'b1;
					st_d  = S_C_A0;
				end
			end
			S_C_A0: begin
				if (cfg.term_count == 5'd1) begin
					st_d = S_FIN;
				end else begin
					rd_en  = 1'b1;
					rd_idx = 5'd1;
					st_d   = S_C_MC;
				end
			end
			S_C_MC: begin
				mul_a = coef;
				mul_b = t1_q;
				st_d  = S_C_SA;
			end
			S_C_SA: begin
				st_d = (n_q == cfg.term_count) ? S_FIN : S_C_MU;
			end
			S_C_MU: begin
				mul_a  = u_q;
				mul_b  = t1_q;
				rd_en  = 1'b1;
				rd_idx = n_q;
				st_d   = S_C_T;
			end
			S_C_T: begin
				st_d = S_C_MC;
			end
			S_FIN: begin
				res_valid = 1'b1;
				if (res_ready) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign rd_addr = AW'(rd_idx);
	assign idle    = st_q == S_IDLE;

	always_ff @(posedge clk) begin
		if (rd_en) oob_q <= 32'(rd_idx) >= COEFF_WORDS;
		unique case (st_q)
			S_IDLE: begin
				flag_q <= 1'b0;
				sum_q  <= '0;
				x_q    <= cheb ? x : xc;
			end
			S_P_ACC0: begin
				acc_q <= coef;
				n_q   <= cfg.term_count - 5'd1;
				sum_q <= 54'(coef);
			end
			S_P_MUL: begin
				prod_q <= mul_p;
			end
			S_P_ADD: begin
				acc_q <= sat32(pa_raw);
				sum_q <= 54'(sat32(pa_raw));
				n_q   <= n_q - 5'd1;
				if (ovf32(pa_raw)) flag_q <= 1'b1;
			end
			S_C_NORM: begin
				if (have_range) begin
					u_q <= (x_q <= cfg.range_min) ? -Q16_ONE : Q16_ONE;
				end else if (cfg.series_type == TYPE_CHEB) begin
					u_q <= x_q;
				end else begin
					u_q <= sat32(u2_raw);
					if (ovf32(u2_raw)) flag_q <= 1'b1;
				end
			end
			S_C_DIV: begin
				if (div_done) u_q <= u_div;
			end
			S_C_A0: begin
				sum_q <= 54'(coef);
				t0_q  <= Q16_ONE;
				t1_q  <= u_q;
				n_q   <= 5'd1;
			end
			S_C_MC: begin
				prod_q <= mul_p;
			end
			S_C_SA: begin
				sum_q <= sum_q + rnd16[53:0];
				if (n_q != cfg.term_count) n_q <= n_q + 5'd1;
			end
			S_C_MU: begin
				prod_q <= mul_p;
			end
			S_C_T: begin
				t0_q <= t1_q;
				t1_q <= sat32(t2_raw);
				if (ovf32(t2_raw)) flag_q <= 1'b1;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign res.series_value = sat32(sum_w);
	assign res.saturated    = flag_q | ovf32(sum_w);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == S_IDLE) else $error("evaluation started while busy");
	a_div_norm: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> st_q == S_C_NORM) else $error("divider started outside normalisation");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN && !res_ready) |=> st_q == S_FIN) else $error("result dropped");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN && res_ready) |=> st_q == S_IDLE) else $error("no return to idle");

endmodule

// File: design/chebyshev_polynomial_series_eval_top.sv
// chebyshev_polynomial_series_eval_top: configuration registers, coefficient
// store, evaluation sequencer and output register. Depends on cps_pkg,
// cps_coeff_mem and cps_seq.

// Evaluates a Q16.16 calibration series at a sample: a Horner polynomial (series_type 0
// or 3) over term_count coefficients, or a Chebyshev sum (types 1 and 2) over
// coefficients 0 to term_count (only coefficient 0 for one term), held in an internal
// store. An item with func 0 writes one coefficient and gives no result. An item with
// func 1 gives one result: a polynomial makes one store read and one pass through the
// shared multiplier per term; a Chebyshev sum makes two multiplies per term, and first
// needs the 16-step bit-serial division for the range mapping when the sample lies
// inside the range (a one-term sum skips the recurrence). One item is worked on at a
// time; a result waits in the output register while the next item is taken.
module chebyshev_polynomial_series_eval_top #(
	parameter int COEFF_WORDS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cps_pkg::cps_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cps_pkg::cps_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import cps_pkg::*;

	localparam int AW = (COEFF_WORDS > 1) ? $clog2(COEFF_WORDS) : 1;

	cps_cfg_t           cfg_q;
	logic               out_valid_q;
	cps_out_t           out_data_q;
	logic               idle, in_acc, slot_free;
	logic               rd_en, res_valid;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_data;
	cps_out_t           res;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SERIES_TYPE: cfg_q.series_type <= cfg_data[1:0];
				CFG_TERM_COUNT:  cfg_q.term_count  <= cfg_data[4:0];
				CFG_RANGE_MIN:   cfg_q.range_min   <= cfg_data;
				CFG_RANGE_MAX:   cfg_q.range_max   <= cfg_data;
			endcase
		end
	end

	cps_coeff_mem #(
		.WORDS (COEFF_WORDS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (in_acc && in_data.func == FUNC_WRITE
		          && 32'(in_data.coeff_index) < COEFF_WORDS),
		.wr_addr (AW'(in_data.coeff_index)),
		.wr_data (in_data.coeff_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cps_seq #(
		.COEFF_WORDS (COEFF_WORDS),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_acc && in_data.func == FUNC_EVAL),
		.x         (in_data.sample),
		.idle      (idle),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (slot_free),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking testbench for chebyshev_polynomial_series_eval_top.
// Queue-fed driver and clocked monitor, with an in-bench model of the series sums.
// Depends on cps_pkg and the design files.
module tb_top;
	import cps_pkg::*;

	localparam int QUIET_GAP = 200;
	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	cps_in_t in_data = '0;
	logic out_valid, out_ready = 0;
	cps_out_t out_data;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	chebyshev_polynomial_series_eval_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	cps_in_t item_q[$];
	cps_out_t sum_q[$];
	bit item_live = 0;
	bit calm = 0;
	int in_gap = 0, out_stall = 0, errors = 0, idle_cycles = 0;

	// model state
	longint coeffs[32];
	logic [1:0] m_type = 0;
	int m_terms = 0;
	longint m_min = 0, m_max = 0;

	task automatic report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic longint clip(longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint rnd(longint v, int k);
		return (v + (64'sd1 << (k - 1))) >>> k;
	endfunction

	function automatic cps_out_t series_sum(logic signed [31:0] xs);
		longint x, u, t, t0, t1, t2, total, acc;
		bit f;
		cps_out_t r;
		f = 0;
		x = 64'(xs);
		total = 0;
		if (m_terms != 0) begin
			if (m_type == TYPE_CHEB || m_type == TYPE_CHEB_SHIFT) begin
				if (m_min < m_max) begin
					if (x <= m_min) t = 0;
					else if (x >= m_max) t = ONE_Q16;
					else t = ((x - m_min) <<< 16) / (m_max - m_min);
					u = 2 * t - ONE_Q16;
				end else if (m_type == TYPE_CHEB) begin
					u = x;
				end else begin
					u = clip(2 * x - ONE_Q16, f);
				end
				total = coeffs[0];
				if (m_terms != 1) begin
					t0 = ONE_Q16;
					t1 = u;
					total += rnd(coeffs[1] * t1, 16);
					for (int n = 2; n <= m_terms; n++) begin
						t2 = clip(rnd(u * t1, 15) - t0, f);
						total += rnd(coeffs[n] * t2, 16);
						t0 = t1;
						t1 = t2;
					end
				end
			end else begin
				if (m_min < m_max) begin
					if (x < m_min) x = m_min;
					if (x > m_max) x = m_max;
				end
				acc = coeffs[m_terms - 1];
				for (int n = m_terms - 1; n > 0; n--)
					acc = clip(rnd(x * acc, 16) + coeffs[n - 1], f);
				total = acc;
			end
			total = clip(total, f);
		end
		r.series_value = total[31:0];
		r.saturated = f;
		return r;
	endfunction

	// sampling, prediction and checking
	always @(posedge clk) begin
		cps_out_t e;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SERIES_TYPE: m_type = cfg_data[1:0];
				CFG_TERM_COUNT: m_terms = int'(cfg_data[4:0]);
				CFG_RANGE_MIN: m_min = 64'($signed(cfg_data));
				CFG_RANGE_MAX: m_max = 64'($signed(cfg_data));
			endcase
		end
		if (in_valid && in_ready) begin
			item_live = 0;
			if (in_data.func == FUNC_WRITE)
				coeffs[in_data.coeff_index] = 64'(in_data.coeff_value);
			else
				sum_q.push_back(series_sum(in_data.sample));
		end
		if (out_valid && out_ready) begin
			if (sum_q.size() == 0) begin
				report("result with nothing expected");
			end else begin
				e = sum_q.pop_front();
				if (out_data.series_value !== e.series_value)
					report($sformatf("series_value %h, expected %h",
						out_data.series_value, e.series_value));
				if (out_data.saturated !== e.saturated)
					report($sformatf("saturated %b, expected %b",
						out_data.saturated, e.saturated));
			end
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// input driver
	always @(negedge clk) begin
		if (!item_live) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (item_q.size() != 0) begin
				in_data <= item_q.pop_front();
				in_valid <= 1;
				item_live = 1;
				if (!calm && $urandom_range(0, 4) == 0)
					in_gap = $urandom_range(1, 13);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_stall--;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (!calm && $urandom_range(0, 7) == 0)
				out_stall = $urandom_range(1, 13);
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_config(logic [1:0] ty, logic [4:0] n, logic [31:0] lo, logic [31:0] hi);
		cfg_write(CFG_SERIES_TYPE, 32'(ty));
		cfg_write(CFG_TERM_COUNT, 32'(n));
		cfg_write(CFG_RANGE_MIN, lo);
		cfg_write(CFG_RANGE_MAX, hi);
	endtask

	task automatic drain();
		wait (item_q.size() == 0 && !item_live && sum_q.size() == 0);
		repeat (QUIET_GAP) @(posedge clk);
	endtask

	function automatic cps_in_t coeff_item(logic [4:0] idx, logic [31:0] val);
		cps_in_t it;
		it.func = FUNC_WRITE;
		it.coeff_index = idx;
		it.coeff_value = val;
		it.sample = $urandom;
		return it;
	endfunction

	function automatic cps_in_t eval_item(logic [31:0] x);
		cps_in_t it;
		it.func = FUNC_EVAL;
		it.coeff_index = 5'($urandom);
		it.coeff_value = $urandom;
		it.sample = x;
		return it;
	endfunction

	function automatic logic [31:0] rand_coeff();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 524288) - 262144;
	endfunction

	function automatic logic [31:0] rand_x();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 524288) - 262144;
	endfunction

	task automatic directed_evals();
		item_q.push_back(eval_item(32'h8000_0000));
		item_q.push_back(eval_item(32'h7fff_ffff));
		item_q.push_back(eval_item(32'h0000_0000));
		item_q.push_back(eval_item(32'hffff_ffff));
		item_q.push_back(eval_item(32'h0001_0000));
		drain();
	endtask

	initial begin
		logic [31:0] lo, hi;
		int count;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// fill every slot so that no unwritten word is ever read
		for (int i = 0; i < 32; i++)
			item_q.push_back(coeff_item(5'(i), (i == 0) ? 32'h7fff_ffff :
				(i == 1) ? 32'h8000_0000 : rand_coeff()));
		item_q.push_back(eval_item(32'h0002_0000));
		drain();

		set_config(2'd0, 5'd0, 32'd0, 32'd0);
		directed_evals();
		set_config(2'd0, 5'd31, 32'hfffe_0000, 32'h0002_0000);
		directed_evals();
		set_config(TYPE_CHEB, 5'd1, 32'd0, 32'd0);
		directed_evals();
		set_config(TYPE_CHEB, 5'd2, 32'h0001_0000, 32'h0001_0000);
		directed_evals();
		set_config(TYPE_CHEB_SHIFT, 5'd5, 32'h0000_0000, 32'hffff_0000);
		directed_evals();
		set_config(2'd3, 5'd4, 32'h0000_0000, 32'h0000_0000);
		directed_evals();
		set_config(TYPE_CHEB, 5'd31, 32'h8000_0000, 32'h7fff_ffff);
		directed_evals();

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 2))
				0: begin
					lo = $urandom;
					hi = $urandom;
				end
				default: begin
					lo = $urandom_range(0, 393216) - 262144;
					hi = lo + $urandom_range(1, 393216);
				end
			endcase
			set_config(2'($urandom_range(0, 3)),
				5'(($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 31 : 0) :
					$urandom_range(1, 8)), lo, hi);
			calm = (ph == 11);
			count = 0;
			while (count < 28) begin
				if ($urandom_range(0, 9) < 3) begin
					item_q.push_back(coeff_item(5'($urandom_range(0, 31)), rand_coeff()));
				end else begin
					item_q.push_back(eval_item(rand_x()));
					count++;
				end
			end
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: filelist.f
design/cps_pkg.sv
design/cps_coeff_mem.sv
design/cps_norm_div.sv
design/cps_seq.sv
design/chebyshev_polynomial_series_eval_top.sv
sim/tb_top.sv
